FILE: hdl/hbsc_pkg.sv
// Shared types, constants and code-word helpers for the Hamming(15,11) byte codec.
// No dependencies; every other file of the block imports this package.
package hbsc_pkg;

  localparam int HBSC_FIX_TOTAL_BITS = 16;
  localparam int DATA_BYTES = 11;
  localparam int CODE_BYTES = 15;
  localparam int WORDS = 8;
  localparam int BLOCK_BITS = CODE_BYTES * 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Code bits whose 1-based position has bit r set.
  localparam logic [14:0] SYN_MASK0 = 15'h5555;
  localparam logic [14:0] SYN_MASK1 = 15'h6666;
  localparam logic [14:0] SYN_MASK2 = 15'h7878;
  localparam logic [14:0] SYN_MASK3 = 15'h7f80;

  typedef logic [7:0] byte_t;

  // One finished block (or error result) waiting to be sent out byte by byte.
  typedef struct packed {
    logic [BLOCK_BITS-1:0] data;
    logic [3:0]            last_idx;
    logic [3:0]            fixes;
    logic [15:0]           msg_fixes;
    logic                  len_err;
  } hbsc_job_t;

  function automatic logic [3:0] syndrome(input logic [14:0] cw);
    syndrome = {^(cw & SYN_MASK3), ^(cw & SYN_MASK2), ^(cw & SYN_MASK1), ^(cw & SYN_MASK0)};
  endfunction

  // Data bits go to positions 3,5,6,7,9..15; parity to 1,2,4,8.
  function automatic logic [14:0] encode_word(input logic [10:0] d);
    logic [14:0] cw;
    logic [3:0]  s;
    cw = {d[10:4], 1'b0, d[3:1], 1'b0, d[0], 2'b00};
    s  = syndrome(cw);
    encode_word = cw | {7'd0, s[3], 3'd0, s[2], 1'b0, s[1], s[0]};
  endfunction

  function automatic logic [10:0] extract_data(input logic [14:0] cw);
    extract_data = {cw[14:8], cw[6:4], cw[2]};
  endfunction

  function automatic logic [14:0] correct_word(input logic [14:0] cw, input logic [3:0] s);
    logic [14:0] flip;
    flip = '0;
    for (int k = 0; k < 15; k++) begin
      flip[k] = (s == 4'(k + 1));
    end
    correct_word = cw ^ flip;
  endfunction

endpackage

FILE: hdl/hbsc_in_if.sv
// Input byte channel of the Hamming(15,11) codec: valid/ready handshake.
// Depends on hbsc_pkg for the byte type.
interface hbsc_in_if import hbsc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  message_end;

  modport source (output valid, output in_byte, output message_end, input ready);
  modport sink (input valid, input in_byte, input message_end, output ready);
endinterface

FILE: hdl/hbsc_out_if.sv
// Result byte channel of the Hamming(15,11) codec: valid/ready handshake.
// Depends on hbsc_pkg for the byte type.
interface hbsc_out_if import hbsc_pkg::*; ();
  logic        valid;
  logic        ready;
  byte_t       out_byte;
  logic        block_last;
  logic [3:0]  block_fixes;
  logic [15:0] message_fixes;
  logic        length_error;

  modport source (output valid, output out_byte, output block_last, output block_fixes,
                  output message_fixes, output length_error, input ready);
  modport sink (input valid, input out_byte, input block_last, input block_fixes,
                input message_fixes, input length_error, output ready);
endinterface

FILE: hdl/hbsc_front.sv
// Front end: collects input bytes into a block, codes a full block as it
// completes and pushes the finished job into the queue. Depends on hbsc_pkg.
module hbsc_front import hbsc_pkg::*; #(
  parameter int FIX_TOTAL_BITS = HBSC_FIX_TOTAL_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  byte_t     in_byte,
  input  logic      in_end,
  input  logic      q_full,
  output logic      push,
  output hbsc_job_t push_job
);

  logic                      mode_r;
  logic [3:0]                count_r, count_nxt;
  logic [FIX_TOTAL_BITS-1:0] fix_total_r, fix_total_nxt;
  byte_t                     store_r [CODE_BYTES];

  logic [3:0]                blen, cnt, cnt_inc;
  logic                      accept, full;
  logic [BLOCK_BITS-1:0]     blk, enc_bits, dec_bits;
  logic [WORDS-1:0]          fix_flags;
  logic [3:0]                fixes;
  logic [FIX_TOTAL_BITS:0]   sum;
  logic [FIX_TOTAL_BITS-1:0] sat, tot_sel;
  logic [15:0]               tot16;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign blen     = (mode_r == MODE_DECODE) ? 4'(CODE_BYTES) : 4'(DATA_BYTES);
  // A count that is not below the block length is taken as zero.
  assign cnt      = (count_r >= blen) ? 4'd0 : count_r;
  assign cnt_inc  = cnt + 4'd1;
  assign full     = (cnt_inc == blen);

  always_comb begin
    for (int i = 0; i < CODE_BYTES; i++) begin
      blk[i*8 +: 8] = (cnt == 4'(i)) ? in_byte : store_r[i];
    end
  end

  always_comb begin
    logic [14:0] cw;
    logic [3:0]  s;
    enc_bits  = '0;
    dec_bits  = '0;
    fix_flags = '0;
    for (int w = 0; w < WORDS; w++) begin
      enc_bits[15*w +: 15] = encode_word(blk[11*w +: 11]);
      cw = blk[15*w +: 15];
      s  = syndrome(cw);
      fix_flags[w] = (s != 4'd0);
      dec_bits[11*w +: 11] = extract_data(correct_word(cw, s));
    end
  end

  assign fixes = (mode_r == MODE_DECODE) ? 4'($countones(fix_flags)) : 4'd0;
  assign sum   = {1'b0, fix_total_r} + {{(FIX_TOTAL_BITS - 3){1'b0}}, fixes};
  assign sat   = sum[FIX_TOTAL_BITS] ? {FIX_TOTAL_BITS{1'b1}} : sum[FIX_TOTAL_BITS-1:0];
  assign tot_sel = full ? sat : fix_total_r;

  generate
    if (FIX_TOTAL_BITS >= 16) begin : g_trunc
      assign tot16 = tot_sel[15:0];
    end else begin : g_ext
      assign tot16 = {{(16 - FIX_TOTAL_BITS){1'b0}}, tot_sel};
    end
  endgenerate

  always_comb begin
    push_job.data      = (mode_r == MODE_DECODE) ? dec_bits : enc_bits;
    push_job.last_idx  = (mode_r == MODE_DECODE) ? 4'(DATA_BYTES - 1) : 4'(CODE_BYTES - 1);
    push_job.fixes     = fixes;
    push_job.msg_fixes = tot16;
    push_job.len_err   = 1'b0;
    if (!full) begin
      push_job.data      = '0;
      push_job.last_idx  = 4'd0;
      push_job.fixes     = 4'd0;
      push_job.len_err   = 1'b1;
    end
  end

  assign push = accept && (full || in_end);

  always_comb begin
    count_nxt     = count_r;
    fix_total_nxt = fix_total_r;
    if (accept) begin
      if (full) begin
        count_nxt     = 4'd0;
        fix_total_nxt = in_end ? '0 : sat;
      end else if (in_end) begin
        count_nxt     = 4'd0;
        fix_total_nxt = '0;
      end else begin
        count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ENCODE;
      count_r     <= 4'd0;
      fix_total_r <= '0;
    end else if (cfg_we) begin
      // A mode change starts a new message.
      mode_r      <= cfg_wdata;
      count_r     <= 4'd0;
      fix_total_r <= '0;
    end else begin
      count_r     <= count_nxt;
      fix_total_r <= fix_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[cnt] <= in_byte;
    end
  end

endmodule

FILE: hdl/hbsc_queue.sv
// Two-entry job queue between the front end and the output serializer.
// Depends on hbsc_pkg for the job type.
module hbsc_queue import hbsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hbsc_job_t push_job,
  output logic      full,
  output logic      head_valid,
  output hbsc_job_t head_job,
  input  logic      pop
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);

  hbsc_job_t          mem_r [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrBits:0]   count_r;

  assign full       = (count_r == (PtrBits + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PtrBits + 1)'(push) - (PtrBits + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hdl/hbsc_back.sv
// Back end: sends the job at the head of the queue out one byte per cycle
// while out_ready is high. Depends on hbsc_pkg for the job type.
module hbsc_back import hbsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  hbsc_job_t head_job,
  output logic      pop,
  input  logic      out_ready,
  output logic      out_valid,
  output byte_t     out_byte,
  output logic      out_last,
  output logic [3:0] out_fixes,
  output logic [15:0] out_msg_fixes,
  output logic      out_len_err
);

  logic [3:0] idx_r, idx_nxt;
  logic       last;

  assign last          = (idx_r == head_job.last_idx);
  assign out_valid     = head_valid;
  assign out_byte      = head_job.data[idx_r*8 +: 8];
  assign out_last      = last;
  assign out_fixes     = head_job.fixes;
  assign out_msg_fixes = head_job.msg_fixes;
  assign out_len_err   = head_job.len_err;
  assign pop           = head_valid && out_ready && last;

  always_comb begin
    idx_nxt = idx_r;
    if (head_valid && out_ready) begin
      idx_nxt = last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: hdl/hamming_15_11_byte_stream_codec_top.sv
// Hamming(15,11) byte-stream codec. Input channel in_ch carries one message
// byte per item with message_end on the last byte; output channel out_ch
// carries result bytes. cfg_we/cfg_wdata write the mode: 0 encodes 11-byte
// blocks into 15 bytes, 1 decodes 15-byte blocks into 11 with correction.
// A byte that completes a block is coded in the cycle it is accepted and the
// job is written to the queue; its first result byte is offered once it is at
// the head of the queue, and the rest follow one per cycle while out_ch.ready
// is high. With the receiver always ready, decode mode takes one input item
// per cycle, while in encode mode the output serializer limits the input rate.
// A message end inside a partial block yields one error item with
// length_error set. A two-job queue sits between the coder and the output,
// so input keeps flowing while the receiver holds ready low, until both
// entries are full; then in_ch.ready drops. Reset (rst_n low, synchronous)
// selects encode mode and clears the byte count, fix total and queue.
// Depends on hbsc_pkg, hbsc_in_if, hbsc_out_if, hbsc_front, hbsc_queue, hbsc_back.
module hamming_15_11_byte_stream_codec_top import hbsc_pkg::*; #(
  parameter int FIX_TOTAL_BITS = HBSC_FIX_TOTAL_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  hbsc_in_if.sink      in_ch,
  hbsc_out_if.source   out_ch
);

  logic      push, q_full, head_valid, pop;
  hbsc_job_t push_job, head_job;

  hbsc_front #(.FIX_TOTAL_BITS(FIX_TOTAL_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_end   (in_ch.message_end),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  hbsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop)
  );

  hbsc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.block_last),
    .out_fixes    (out_ch.block_fixes),
    .out_msg_fixes(out_ch.message_fixes),
    .out_len_err  (out_ch.length_error)
  );

endmodule
